[design/dsi_pkg.sv]
// Shared types, widths and reset constants of the depth scale interpolator.
// Used by the channel interfaces and every module of the block; depends on nothing.
package dsi_pkg;

  localparam int COORD_W    = 11;
  localparam int ZOOM_W     = 8;
  localparam int DEPTH_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Divider: quotient bits, divisor width and dividend width (num * 255 fits in 19 bits).
  localparam int Q_W        = 8;
  localparam int DEN_W      = COORD_W;
  localparam int DIV_W      = DEN_W + Q_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  localparam logic signed [COORD_W-1:0] FAR_LINE_RST  = 11'sd88;
  localparam logic signed [COORD_W-1:0] MID_LINE_RST  = 11'sd124;
  localparam logic signed [COORD_W-1:0] NEAR_LINE_RST = 11'sd176;
  localparam logic [ZOOM_W-1:0]         FAR_ZOOM_RST  = 8'hB8;
  localparam logic [ZOOM_W-1:0]         MID_ZOOM_RST  = 8'hD0;
  localparam logic [ZOOM_W-1:0]         NEAR_ZOOM_RST = 8'hEC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAR_LINE        = 3'd0,
    REG_MID_LINE        = 3'd1,
    REG_NEAR_LINE       = 3'd2,
    REG_FAR_ZOOM        = 3'd3,
    REG_MID_ZOOM        = 3'd4,
    REG_NEAR_ZOOM       = 3'd5,
    REG_KEEP_HORIZONTAL = 3'd6
  } dsi_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] far_line;
    logic signed [COORD_W-1:0] mid_line;
    logic signed [COORD_W-1:0] near_line;
    logic [ZOOM_W-1:0]         far_zoom;
    logic [ZOOM_W-1:0]         mid_zoom;
    logic [ZOOM_W-1:0]         near_zoom;
    logic                      keep_horizontal;
  } dsi_cfg_t;

  // Divider state carried from stage to stage.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } dsi_div_t;

  // Everything else about a word that rides alongside the divider.
  typedef struct packed {
    logic [ZOOM_W-1:0]         base;
    logic signed [ZOOM_W:0]    diff;
    logic                      direct;
    logic [ZOOM_W-1:0]         direct_zoom;
    logic                      write_vertical;
    logic                      write_horizontal;
    logic signed [DEPTH_W-1:0] depth_delta;
    logic                      depth_valid;
  } dsi_side_t;

endpackage

[design/dsi_if.sv]
// Valid/ready channel interfaces for the input and result words.
// Depends on dsi_pkg for field widths.
interface dsi_in_if;
  import dsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      shown;
  modport source (output valid, kind, pos_y, pos_z, shown, input ready);
  modport sink   (input valid, kind, pos_y, pos_z, shown, output ready);
endinterface

interface dsi_out_if;
  import dsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ZOOM_W-1:0]         zoom;
  logic                      write_vertical;
  logic                      write_horizontal;
  logic signed [DEPTH_W-1:0] depth_delta;
  logic                      depth_valid;
  modport source (output valid, zoom, write_vertical, write_horizontal, depth_delta,
                  depth_valid, input ready);
  modport sink   (input valid, zoom, write_vertical, write_horizontal, depth_delta,
                  depth_valid, output ready);
endinterface

[design/depth_scale_interpolator.sv]
// Depth scale interpolator: turns a sprite's screen y into an 8-bit zoom, with an optional
// depth offset. Input words arrive on in_ch and result words leave on out_ch, both
// valid/ready channels; a word moves at a clock edge where valid and ready are both high.
// Each input word yields exactly one result word, in order.
// The pipeline is six register stages deep: line selection, four divider stages that each
// resolve two quotient bits of (y - lo) * 255 / span, and the blend stage, which is also the
// output register. A word passes through them in that order and is offered on out_ch from the
// blend stage. While the receiver takes every result word, a new word can be taken every
// cycle, so the sustained rate is one word per clock; the divider chain sets the depth.
// Each stage moves on whenever it is empty or the stage after it moves, so bubbles close up
// and in_ch stays ready while a finished word waits on a stalled receiver, until every stage
// is full. A stall holds each word that has a full stage ahead of it; nothing is dropped or repeated.
// Configuration is written through cfg_write/cfg_index/cfg_data, one register per cycle,
// and must only change while the pipeline is empty. Synchronous reset empties the pipeline
// and restores the register defaults.
module depth_scale_interpolator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsi_pkg::CFG_DATA_W-1:0]    cfg_data,
  dsi_in_if.sink                            in_ch,
  dsi_out_if.source                         out_ch
);
  import dsi_pkg::*;

  localparam int NSTG = DIV_STAGES + 2;

  dsi_cfg_t  cfg;
  logic [NSTG-1:0] stage_valid;
  logic [NSTG-1:0] advance;
  dsi_div_t  div_pipe  [DIV_STAGES+1];
  dsi_side_t side_pipe [DIV_STAGES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far_line        <= FAR_LINE_RST;
      cfg.mid_line        <= MID_LINE_RST;
      cfg.near_line       <= NEAR_LINE_RST;
      cfg.far_zoom        <= FAR_ZOOM_RST;
      cfg.mid_zoom        <= MID_ZOOM_RST;
      cfg.near_zoom       <= NEAR_ZOOM_RST;
      cfg.keep_horizontal <= 1'b0;
    end else if (cfg_write) begin
      unique case (dsi_reg_t'(cfg_index))
        REG_FAR_LINE:        cfg.far_line        <= cfg_data;
        REG_MID_LINE:        cfg.mid_line        <= cfg_data;
        REG_NEAR_LINE:       cfg.near_line       <= cfg_data;
        REG_FAR_ZOOM:        cfg.far_zoom        <= cfg_data[ZOOM_W-1:0];
        REG_MID_ZOOM:        cfg.mid_zoom        <= cfg_data[ZOOM_W-1:0];
        REG_NEAR_ZOOM:       cfg.near_zoom       <= cfg_data[ZOOM_W-1:0];
        REG_KEEP_HORIZONTAL: cfg.keep_horizontal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage k moves on when it is empty or stage k+1 moves on; the last stage looks at the
  // receiver. This lets bubbles collapse while the output word is held.
  always_comb begin
    advance[NSTG-1] = ~stage_valid[NSTG-1] | out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      advance[k] = ~stage_valid[k] | advance[k+1];
    end
  end

  assign in_ch.ready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (advance[0]) begin
        stage_valid[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (advance[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  dsi_select u_select (
    .clk    (clk),
    .load   (advance[0]),
    .cfg    (cfg),
    .kind   (in_ch.kind),
    .pos_y  (in_ch.pos_y),
    .pos_z  (in_ch.pos_z),
    .shown  (in_ch.shown),
    .div_q  (div_pipe[0]),
    .side_q (side_pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    dsi_div_stage #(
      .FIRST_BIT (Q_W - 1 - g * DIV_STEPS),
      .STEPS     (DIV_STEPS)
    ) u_div (
      .clk     (clk),
      .load    (advance[g+1]),
      .div_in  (div_pipe[g]),
      .side_in (side_pipe[g]),
      .div_q   (div_pipe[g+1]),
      .side_q  (side_pipe[g+1])
    );
  end

  dsi_blend u_blend (
    .clk              (clk),
    .load             (advance[NSTG-1]),
    .div_in           (div_pipe[DIV_STAGES]),
    .side_in          (side_pipe[DIV_STAGES]),
    .zoom             (out_ch.zoom),
    .write_vertical   (out_ch.write_vertical),
    .write_horizontal (out_ch.write_horizontal),
    .depth_delta      (out_ch.depth_delta),
    .depth_valid      (out_ch.depth_valid)
  );

  assign out_ch.valid = stage_valid[NSTG-1];

`ifndef NO_ASSERTIONS
  // A hidden sprite never writes a zoom and reports zoom zero.
  a_hidden_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.write_vertical |-> out_ch.zoom == '0 && !out_ch.write_horizontal)
    else $error("hidden word carries a zoom write");

  // The horizontal write never appears without the vertical one.
  a_write_pair: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.write_horizontal |-> out_ch.write_vertical)
    else $error("horizontal write without vertical write");

  // Interpolation fractions stay below 255 because the offset is smaller than the span.
  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    stage_valid[NSTG-2] && !side_pipe[DIV_STAGES].direct |-> div_pipe[DIV_STAGES].quo != '1)
    else $error("divider quotient out of range");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("result word offered straight after reset");
`endif

endmodule

[design/dsi_select.sv]
// First pipeline stage: line comparisons, segment choice and divider set-up.
// Depends on dsi_pkg.
module dsi_select (
  input  logic                              clk,
  input  logic                              load,
  input  dsi_pkg::dsi_cfg_t                 cfg,
  input  logic                              kind,
  input  logic signed [dsi_pkg::COORD_W-1:0] pos_y,
  input  logic signed [dsi_pkg::COORD_W-1:0] pos_z,
  input  logic                              shown,
  output dsi_pkg::dsi_div_t                 div_q,
  output dsi_pkg::dsi_side_t                side_q
);
  import dsi_pkg::*;

  dsi_div_t  div_d;
  dsi_side_t side_d;

  always_comb begin
    logic signed [COORD_W:0] y, lo, hi, num, den;
    logic [ZOOM_W-1:0]       a, b;
    logic [DEN_W-1:0]        num_u;
    y = {pos_y[COORD_W-1], pos_y};
    if (pos_y < cfg.mid_line) begin
      lo = {cfg.far_line[COORD_W-1], cfg.far_line};
      hi = {cfg.mid_line[COORD_W-1], cfg.mid_line};
      a  = cfg.far_zoom;
      b  = cfg.mid_zoom;
    end else begin
      lo = {cfg.mid_line[COORD_W-1], cfg.mid_line};
      hi = {cfg.near_line[COORD_W-1], cfg.near_line};
      a  = cfg.mid_zoom;
      b  = cfg.near_zoom;
    end
    num   = y - lo;
    den   = hi - lo;
    num_u = num[DEN_W-1:0];

    div_d.rem = {num_u, {Q_W{1'b0}}} - {{Q_W{1'b0}}, num_u};
    div_d.den = den[DEN_W-1:0];
    div_d.quo = '0;

    side_d.base = a;
    side_d.diff = $signed({1'b0, b}) - $signed({1'b0, a});
    side_d.direct = 1'b1;
    if (!shown) begin
      side_d.direct_zoom = '0;
    end else if (pos_y <= cfg.far_line) begin
      side_d.direct_zoom = cfg.far_zoom;
    end else if (pos_y >= cfg.near_line) begin
      side_d.direct_zoom = cfg.near_zoom;
    end else if (den <= 0) begin
      side_d.direct_zoom = b;
    end else begin
      side_d.direct      = 1'b0;
      side_d.direct_zoom = b;
    end
    side_d.write_vertical   = shown;
    side_d.write_horizontal = shown & ~cfg.keep_horizontal;
    side_d.depth_valid      = kind;
    side_d.depth_delta      = kind ? ({cfg.near_line[COORD_W-1], cfg.near_line}
                                      - {pos_z[COORD_W-1], pos_z}) : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      div_q  <= div_d;
      side_q <= side_d;
    end
  end

endmodule

[design/dsi_div_stage.sv]
// One stage of the restoring divider: resolves STEPS quotient bits from FIRST_BIT down.
// Depends on dsi_pkg.
module dsi_div_stage #(
  parameter int FIRST_BIT = dsi_pkg::Q_W - 1,
  parameter int STEPS     = dsi_pkg::DIV_STEPS
) (
  input  logic               clk,
  input  logic               load,
  input  dsi_pkg::dsi_div_t  div_in,
  input  dsi_pkg::dsi_side_t side_in,
  output dsi_pkg::dsi_div_t  div_q,
  output dsi_pkg::dsi_side_t side_q
);
  import dsi_pkg::*;

  dsi_div_t div_d;

  always_comb begin
    logic [DIV_W-1:0] trial;
    div_d = div_in;
    for (int s = 0; s < STEPS; s++) begin
      trial = {{Q_W{1'b0}}, div_in.den} << (FIRST_BIT - s);
      if (div_d.rem >= trial) begin
        div_d.rem                 = div_d.rem - trial;
        div_d.quo[FIRST_BIT - s]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      div_q  <= div_d;
      side_q <= side_in;
    end
  end

endmodule

[design/dsi_blend.sv]
// Last pipeline stage: blends the segment end zooms by the quotient and registers the word.
// Depends on dsi_pkg.
module dsi_blend (
  input  logic                                clk,
  input  logic                                load,
  input  dsi_pkg::dsi_div_t                   div_in,
  input  dsi_pkg::dsi_side_t                  side_in,
  output logic [dsi_pkg::ZOOM_W-1:0]          zoom,
  output logic                                write_vertical,
  output logic                                write_horizontal,
  output logic signed [dsi_pkg::DEPTH_W-1:0]  depth_delta,
  output logic                                depth_valid
);
  import dsi_pkg::*;

  logic signed [2*ZOOM_W+1:0] prod;
  logic [ZOOM_W-1:0]          zoom_d;

  // Arithmetic shift by eight is the floor division; only the low byte of the sum survives.
  assign prod   = side_in.diff * $signed({1'b0, div_in.quo});
  assign zoom_d = side_in.direct ? side_in.direct_zoom
                                 : side_in.base + prod[2*ZOOM_W-1:ZOOM_W];

  always_ff @(posedge clk) begin
    if (load) begin
      zoom             <= zoom_d;
      write_vertical   <= side_in.write_vertical;
      write_horizontal <= side_in.write_horizontal;
      depth_delta      <= side_in.depth_delta;
      depth_valid      <= side_in.depth_valid;
    end
  end

endmodule
